/* rtl/rgbpwm_pkg.sv */
// ----------------------------------------------------------------------------
// rgbpwm_pkg
// Shared types, constants and the preset color table for the LED bit encoder.
// ----------------------------------------------------------------------------
package rgbpwm_pkg;

  localparam int unsigned MaxLeds    = 1024;
  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned IdxW       = $clog2(MaxLeds);
  localparam int unsigned CountW     = IdxW + 1;
  localparam int unsigned BitCntW    = $clog2(BitsPerLed);
  localparam int unsigned AddrW      = 15;
  localparam int unsigned DutyW      = 16;
  localparam int unsigned LevelW     = 8;
  localparam int unsigned ColorW     = 3 * LevelW;

  localparam logic [DutyW-1:0]   PwmPeriodReset = 16'd90;
  localparam logic [CountW-1:0]  LedCountReset  = '0;
  localparam logic [BitCntW-1:0] LastBitPos     = BitCntW'(BitsPerLed - 1);

  // ceil(2^17 / 3): exact floor division by three for any value below 2^17
  localparam int unsigned       Recip3Shift = 17;
  localparam logic [16:0]       Recip3      = 17'd43691;

  localparam logic [LevelW-1:0] LevelFull   = 8'd255;
  localparam logic [LevelW-1:0] LevelOrange = 8'd80;
  localparam logic [LevelW-1:0] LevelYellow = 8'd180;
  localparam logic [LevelW-1:0] LevelOff    = 8'd0;

  typedef enum logic [0:0] {
    CMD_RAW    = 1'b0,
    CMD_PRESET = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_PWM_PERIOD = 1'b0,
    REG_LED_COUNT  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    PRESET_OFF     = 4'd0,
    PRESET_RED     = 4'd1,
    PRESET_ORANGE  = 4'd2,
    PRESET_YELLOW  = 4'd3,
    PRESET_GREEN   = 4'd4,
    PRESET_CYAN    = 4'd5,
    PRESET_BLUE    = 4'd6,
    PRESET_MAGENTA = 4'd7,
    PRESET_WHITE   = 4'd8
  } preset_t;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [ColorW-1:0] grb;
  } entry_t;

  typedef struct packed {
    logic [DutyW-1:0] hi;
    logic [DutyW-1:0] lo;
  } duty_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  function automatic rgb_t preset_rgb(input logic [3:0] sel);
    rgb_t c;
    c = '{red: LevelOff, green: LevelOff, blue: LevelOff};
    case (sel)
      PRESET_RED:     c.red = LevelFull;
      PRESET_ORANGE:  begin
        c.red   = LevelFull;
        c.green = LevelOrange;
      end
      PRESET_YELLOW:  begin
        c.red   = LevelFull;
        c.green = LevelYellow;
      end
      PRESET_GREEN:   c.green = LevelFull;
      PRESET_CYAN:    begin
        c.green = LevelFull;
        c.blue  = LevelFull;
      end
      PRESET_BLUE:    c.blue = LevelFull;
      PRESET_MAGENTA: begin
        c.red  = LevelFull;
        c.blue = LevelFull;
      end
      PRESET_WHITE:   begin
        c.red   = LevelFull;
        c.green = LevelFull;
        c.blue  = LevelFull;
      end
      default: c = '{red: LevelOff, green: LevelOff, blue: LevelOff};
    endcase
    return c;
  endfunction

  function automatic logic [LevelW-1:0] scale_level(input logic [LevelW-1:0] level,
                                                    input logic [LevelW-1:0] bright);
    logic [2*LevelW-1:0] prod;
    prod = level * bright;
    return prod[2*LevelW-1:LevelW];
  endfunction

endpackage

/* rtl/rgbpwm_cfg.sv */
// ----------------------------------------------------------------------------
// rgbpwm_cfg
// Configuration registers and the registered one/zero compare values.
// ----------------------------------------------------------------------------
module rgbpwm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [15:0]                 cfg_data,
  output logic [rgbpwm_pkg::CountW-1:0] led_count,
  output rgbpwm_pkg::duty_t           duty
);
  import rgbpwm_pkg::*;

  logic [DutyW-1:0]  pwm_period_r, pwm_period_nxt;
  logic [CountW-1:0] led_count_r, led_count_nxt;
  duty_t             duty_r, duty_nxt;
  logic [16:0]       lo_num, hi_num;
  logic [33:0]       lo_prod, hi_prod;

  assign cfg_ready = 1'b1;

  always_comb begin
    pwm_period_nxt = pwm_period_r;
    led_count_nxt  = led_count_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PWM_PERIOD: pwm_period_nxt = cfg_data;
        REG_LED_COUNT:  led_count_nxt  = cfg_data[CountW-1:0];
        default: ;
      endcase
    end
    lo_num      = {1'b0, pwm_period_r};
    hi_num      = {pwm_period_r, 1'b0};
    lo_prod     = {17'b0, lo_num} * {17'b0, Recip3};
    hi_prod     = {17'b0, hi_num} * {17'b0, Recip3};
    duty_nxt.lo = lo_prod[Recip3Shift+DutyW-1:Recip3Shift];
    duty_nxt.hi = hi_prod[Recip3Shift+DutyW-1:Recip3Shift];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= PwmPeriodReset;
      led_count_r  <= LedCountReset;
    end else begin
      pwm_period_r <= pwm_period_nxt;
      led_count_r  <= led_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    duty_r <= duty_nxt;
  end

  assign led_count = (led_count_r > CountW'(MaxLeds)) ? CountW'(MaxLeds) : led_count_r;
  assign duty      = duty_r;

endmodule

/* rtl/rgbpwm_front.sv */
// ----------------------------------------------------------------------------
// rgbpwm_front
// Accepts pixel writes, drops out-of-range ones, resolves and scales color.
// ----------------------------------------------------------------------------
module rgbpwm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [rgbpwm_pkg::IdxW-1:0]   in_pixel_index,
  input  logic [rgbpwm_pkg::LevelW-1:0] in_red,
  input  logic [rgbpwm_pkg::LevelW-1:0] in_green,
  input  logic [rgbpwm_pkg::LevelW-1:0] in_blue,
  input  logic [3:0]                    in_preset_color,
  input  logic [rgbpwm_pkg::LevelW-1:0] in_brightness,
  input  logic [rgbpwm_pkg::CountW-1:0] led_count,
  input  logic                          q_full,
  output logic                          q_push,
  output rgbpwm_pkg::entry_t            q_wdata
);
  import rgbpwm_pkg::*;

  logic   f_valid_r, f_valid_nxt;
  entry_t f_entry_r, f_entry_nxt;
  logic   accept, in_range;
  rgb_t   src;

  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign in_range = {1'b0, in_pixel_index} < led_count;
  assign q_push   = f_valid_r && !q_full;
  assign q_wdata  = f_entry_r;

  always_comb begin
    if (cmd_t'(in_command) == CMD_PRESET) begin
      src = preset_rgb(in_preset_color);
    end else begin
      src = '{red: in_red, green: in_green, blue: in_blue};
    end
    f_entry_nxt.idx = in_pixel_index;
    f_entry_nxt.grb = {scale_level(src.green, in_brightness),
                       scale_level(src.red, in_brightness),
                       scale_level(src.blue, in_brightness)};
    f_valid_nxt = f_valid_r;
    if (q_push) begin
      f_valid_nxt = 1'b0;
    end
    if (accept && in_range) begin
      f_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry_r <= f_entry_nxt;
    end
  end

endmodule

/* rtl/rgbpwm_queue.sv */
// ----------------------------------------------------------------------------
// rgbpwm_queue
// Two-entry queue of scaled pixels between the front and the bit serializer.
// ----------------------------------------------------------------------------
module rgbpwm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rgbpwm_pkg::entry_t wdata,
  output logic               full,
  input  logic               pop,
  output rgbpwm_pkg::qhead_t head
);
  import rgbpwm_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head.valid = count_r != 2'd0;
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/rgbpwm_back.sv */
// ----------------------------------------------------------------------------
// rgbpwm_back
// Shifts out the 24 color bits of one pixel as compare values, MSB first.
// ----------------------------------------------------------------------------
module rgbpwm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rgbpwm_pkg::qhead_t           head,
  output logic                         pop,
  input  rgbpwm_pkg::duty_t            duty,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rgbpwm_pkg::AddrW-1:0] out_buffer_address,
  output logic [rgbpwm_pkg::DutyW-1:0] out_duty_value,
  output logic                         out_last_bit
);
  import rgbpwm_pkg::*;

  logic               busy_r, busy_nxt;
  logic [ColorW-1:0]  grb_r, grb_nxt;
  logic [BitCntW-1:0] bit_r, bit_nxt;
  logic [AddrW-1:0]   addr_r, addr_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [AddrW-1:0]   oaddr_r, oaddr_nxt;
  logic [DutyW-1:0]   oduty_r, oduty_nxt;
  logic               olast_r, olast_nxt;
  logic               emit, is_last;
  logic [AddrW-1:0]   base;

  assign is_last = bit_r == LastBitPos;
  assign emit    = busy_r && (!ovalid_r || !out_stall);
  assign pop     = head.valid && (!busy_r || (emit && is_last));
  assign base    = (AddrW'(head.entry.idx) << 4) + (AddrW'(head.entry.idx) << 3);

  always_comb begin
    busy_nxt   = busy_r;
    grb_nxt    = grb_r;
    bit_nxt    = bit_r;
    addr_nxt   = addr_r;
    ovalid_nxt = ovalid_r && out_stall;
    oaddr_nxt  = oaddr_r;
    oduty_nxt  = oduty_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      oaddr_nxt  = addr_r;
      oduty_nxt  = grb_r[ColorW-1] ? duty.hi : duty.lo;
      olast_nxt  = is_last;
      grb_nxt    = {grb_r[ColorW-2:0], 1'b0};
      bit_nxt    = bit_r + 1'b1;
      addr_nxt   = addr_r + 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      grb_nxt  = head.entry.grb;
      bit_nxt  = '0;
      addr_nxt = base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grb_r   <= grb_nxt;
    bit_r   <= bit_nxt;
    addr_r  <= addr_nxt;
    oaddr_r <= oaddr_nxt;
    oduty_r <= oduty_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid          = ovalid_r;
  assign out_buffer_address = oaddr_r;
  assign out_duty_value     = oduty_r;
  assign out_last_bit       = olast_r;

endmodule

/* rtl/rgb_led_pwm_bit_encoder.sv */
// ----------------------------------------------------------------------------
// rgb_led_pwm_bit_encoder
// GRB LED pixel writes in, one PWM compare value and buffer slot per bit out.
// ----------------------------------------------------------------------------
// Each accepted pixel write whose index is below led_count produces 24
// results, one per cycle while out_stall is low, green MSB first; writes at
// or beyond led_count are accepted and dropped. The single-bit serializer
// in the back end sets the throughput. A write passes the front register,
// queue and serializer before its first result is registered at the output.
// A two-entry queue holds scaled pixels, so the input keeps taking writes
// while a pixel is shifted out, until queue and front register are full.
// Compare values: floor(period/3) for a zero, floor(2*period/3) for a one.
module rgb_led_pwm_bit_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [rgbpwm_pkg::IdxW-1:0]   in_pixel_index,
  input  logic [rgbpwm_pkg::LevelW-1:0] in_red,
  input  logic [rgbpwm_pkg::LevelW-1:0] in_green,
  input  logic [rgbpwm_pkg::LevelW-1:0] in_blue,
  input  logic [3:0]                    in_preset_color,
  input  logic [rgbpwm_pkg::LevelW-1:0] in_brightness,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rgbpwm_pkg::AddrW-1:0]  out_buffer_address,
  output logic [rgbpwm_pkg::DutyW-1:0]  out_duty_value,
  output logic                          out_last_bit
);
  import rgbpwm_pkg::*;

  logic [CountW-1:0] led_count;
  duty_t             duty;
  logic              q_full, q_push, q_pop;
  entry_t            q_wdata;
  qhead_t            q_head;

  rgbpwm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .led_count (led_count),
    .duty      (duty)
  );

  rgbpwm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_pixel_index  (in_pixel_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_preset_color (in_preset_color),
    .in_brightness   (in_brightness),
    .led_count       (led_count),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  rgbpwm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head)
  );

  rgbpwm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .pop                (q_pop),
    .duty               (duty),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_buffer_address (out_buffer_address),
    .out_duty_value     (out_duty_value),
    .out_last_bit       (out_last_bit)
  );

endmodule
